// ===== src/lzrw_pkg.sv =====
// ----------------------------------------------------------------------------
// lzrw_pkg
// Widths, codes and command-byte fields shared by the ring window expander.
// ----------------------------------------------------------------------------
package lzrw_pkg;

    localparam int BYTE_W    = 8;
    localparam int WIN_AW    = 8;
    localparam int OUT_LANES = 4;
    localparam int COUNT_W   = 3;
    localparam int LEN_W     = 9;
    localparam int LIT_W     = 7;

    localparam int                 CMD_MATCH_BIT = 7;
    localparam logic [LIT_W-1:0]   CMD_LEN_MASK  = 7'h7f;
    localparam logic [BYTE_W-1:0]  CMD_END       = 8'h00;
    localparam logic [LEN_W-1:0]   LEN_MAX       = 9'd256;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WIN_AW-1:0] t_win_addr;

endpackage

// ===== src/lz_ring_window_expander.sv =====
// ----------------------------------------------------------------------------
// lz_ring_window_expander
// Streaming LZ77 decoder with a 256-byte ring history and four output lanes.
// ----------------------------------------------------------------------------
// The input channel takes one compressed byte per request. Command bytes
// produce no result, each literal byte produces one result with one lane,
// and a zero command produces one end result with no lanes that also resets
// the write position. A distance byte starts a match copy that produces one
// result per four copied bytes, the last one possibly short.
// Literal and command bytes are taken while the output register is free or
// being emptied, and a literal result is registered in the cycle after its
// request is taken. A match copy reads each byte from the history memory
// and writes it back, and emits a result after every four bytes and at its
// end. The input is not ready meanwhile. After reset the history memory is
// cleared, one entry per cycle, before the first request is taken.
// When the receiver stalls, the result stays in the output register and
// the decoder waits until it is taken; no result is lost.
// ----------------------------------------------------------------------------
module lz_ring_window_expander
    import lzrw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_in_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_byte_count,
    output logic [7:0]         o_lane0,
    output logic [7:0]         o_lane1,
    output logic [7:0]         o_lane2,
    output logic [7:0]         o_lane3,
    output logic               o_last_of_run,
    output logic               o_stream_end
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_LIT,
        PH_DIST
    } t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    t_win_addr         r_wp, n_wp;
    t_win_addr         r_rd, n_rd;
    logic [LIT_W-1:0]  r_lit, n_lit;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic [COUNT_W-1:0] r_fill, n_fill;
    t_byte             r_lane [OUT_LANES];
    t_byte             n_lane [OUT_LANES];

    logic              r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_count, n_count;
    t_byte             r_out [OUT_LANES];
    t_byte             n_out [OUT_LANES];
    logic              r_last, n_last;
    logic              r_end, n_end;

    t_byte             r_hist [2**WIN_AW];
    t_byte             r_rdata;
    logic              mem_we;
    t_win_addr         mem_wa;
    t_byte             mem_wd;

    logic              slot_free;
    logic              in_take;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_wa] <= mem_wd;
        end
        r_rdata <= r_hist[r_rd];
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_rd        = r_rd;
        n_lit       = r_lit;
        n_remain    = r_remain;
        n_fill      = r_fill;
        n_lane      = r_lane;
        n_out_valid = r_out_valid && !i_out_ready;
        n_count     = r_count;
        n_out       = r_out;
        n_last      = r_last;
        n_end       = r_end;
        mem_we      = 1'b0;
        mem_wa      = r_wp;
        mem_wd      = r_rdata;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_rd;
                mem_wd = '0;
                n_rd   = r_rd + 1'b1;
                if (r_rd == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    unique case (r_phase)
                        PH_LIT: begin
                            mem_we      = 1'b1;
                            mem_wd      = i_in_byte;
                            n_wp        = r_wp + 1'b1;
                            n_out_valid = 1'b1;
                            n_count     = COUNT_W'(1);
                            n_out[0]    = i_in_byte;
                            for (int k = 1; k < OUT_LANES; k++) begin
                                n_out[k] = '0;
                            end
                            n_last      = 1'b1;
                            n_end       = 1'b0;
                            n_lit       = r_lit - 1'b1;
                            if (r_lit == LIT_W'(1)) begin
                                n_phase = PH_CMD;
                            end
                        end
                        PH_DIST: begin
                            n_rd     = r_wp - i_in_byte;
                            n_fill   = '0;
                            n_phase  = PH_CMD;
                            n_state  = S_READ;
                        end
                        default: begin
                            if (i_in_byte == CMD_END) begin
                                n_out_valid = 1'b1;
                                n_count     = '0;
                                for (int k = 0; k < OUT_LANES; k++) begin
                                    n_out[k] = '0;
                                end
                                n_last   = 1'b1;
                                n_end    = 1'b1;
                                n_wp     = '0;
                                n_phase  = PH_CMD;
                                n_lit    = '0;
                                n_remain = '0;
                            end else if (i_in_byte[CMD_MATCH_BIT]) begin
                                if ((i_in_byte[LIT_W-1:0] & CMD_LEN_MASK) == '0) begin
                                    n_remain = LEN_MAX;
                                end else begin
                                    n_remain = {2'b00, i_in_byte[LIT_W-1:0] & CMD_LEN_MASK};
                                end
                                n_phase = PH_DIST;
                            end else begin
                                n_lit   = i_in_byte[LIT_W-1:0] & CMD_LEN_MASK;
                                n_phase = PH_LIT;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                mem_we   = 1'b1;
                mem_wd   = r_rdata;
                n_wp     = r_wp + 1'b1;
                n_rd     = r_rd + 1'b1;
                n_lane[r_fill[1:0]] = r_rdata;
                n_fill   = r_fill + 1'b1;
                n_remain = r_remain - 1'b1;
                if (r_fill == COUNT_W'(OUT_LANES - 1) || r_remain == LEN_W'(1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_count     = r_fill;
                    n_out       = r_lane;
                    n_last      = (r_remain == '0);
                    n_end       = 1'b0;
                    n_fill      = '0;
                    for (int k = 0; k < OUT_LANES; k++) begin
                        n_lane[k] = '0;
                    end
                    n_state     = (r_remain == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_CMD;
            r_wp        <= '0;
            r_rd        <= '0;
            r_lit       <= '0;
            r_remain    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < OUT_LANES; k++) begin
                r_lane[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_rd        <= n_rd;
            r_lit       <= n_lit;
            r_remain    <= n_remain;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_lane      <= n_lane;
        end
        r_count <= n_count;
        r_out   <= n_out;
        r_last  <= n_last;
        r_end   <= n_end;
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_count  = r_count;
    assign o_lane0       = r_out[0];
    assign o_lane1       = r_out[1];
    assign o_lane2       = r_out[2];
    assign o_lane3       = r_out[3];
    assign o_last_of_run = r_last;
    assign o_stream_end  = r_end;

endmodule
